>>> rtl/ffea_pkg.sv
package ffea_pkg;

    localparam int FREE_SLOTS = 64;
    localparam int ADDR_BITS  = 31;
    localparam int IDX_W      = $clog2(FREE_SLOTS);
    localparam int CNT_W      = $clog2(FREE_SLOTS + 1);

    // byte counts and extents as they appear on the ports
    localparam int KLEN_W  = 16;
    localparam int VLEN_W  = 20;
    localparam int FIELD_W = 31;
    // 11 + 65535 + 1048575 still fits
    localparam int NEED_BITS = 21;

    localparam int HEADER_BYTES = 9;
    localparam int TERM_BYTES   = 2;

    localparam int S_DATA_W = 120;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 128;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_END = 1'b1;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_UPDATE  = 2'd1,
        REQ_REMOVE  = 2'd2,
        REQ_RELEASE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIT_SCAN,
        ST_FIT_COMMIT,
        ST_FREE_SCAN,
        ST_FREE_COMMIT,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic                 rd_en;
        logic [IDX_W-1:0]     rd_addr;
        logic                 wr_en;
        logic [IDX_W-1:0]     wr_idx;
        logic [ADDR_BITS-1:0] wr_begin;
        logic [ADDR_BITS-1:0] wr_last;
        logic                 clr_en;
        logic [IDX_W-1:0]     clr_idx;
    } t_tbl_cmd;

    typedef struct packed {
        logic                 vld;
        logic [IDX_W-1:0]     idx;
        logic                 used;
        logic [ADDR_BITS-1:0] begin_a;
        logic [ADDR_BITS-1:0] last_a;
    } t_rd_beat;

    typedef struct packed {
        logic                 fit_hit;
        logic [IDX_W-1:0]     fit_idx;
        logic [ADDR_BITS-1:0] fit_begin;
        logic [ADDR_BITS-1:0] fit_last;
        logic                 match_hit;
        logic [IDX_W-1:0]     match_idx;
        logic                 free_hit;
        logic [IDX_W-1:0]     free_idx;
    } t_scan_res;

endpackage

>>> rtl/ffea_table.sv
module ffea_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ffea_pkg::t_tbl_cmd  i_cmd,
    output ffea_pkg::t_rd_beat  o_beat
);

    logic [ffea_pkg::ADDR_BITS-1:0] r_mem_begin [ffea_pkg::FREE_SLOTS];
    logic [ffea_pkg::ADDR_BITS-1:0] r_mem_last  [ffea_pkg::FREE_SLOTS];
    logic [ffea_pkg::FREE_SLOTS-1:0] r_used;

    logic                            r_rd_vld;
    logic [ffea_pkg::IDX_W-1:0]      r_rd_idx;
    logic                            r_rd_used;
    logic [ffea_pkg::ADDR_BITS-1:0]  r_rd_begin;
    logic [ffea_pkg::ADDR_BITS-1:0]  r_rd_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem_begin[i_cmd.wr_idx] <= i_cmd.wr_begin;
            r_mem_last[i_cmd.wr_idx]  <= i_cmd.wr_last;
        end
        if (i_cmd.rd_en) begin
            r_rd_begin <= r_mem_begin[i_cmd.rd_addr];
            r_rd_last  <= r_mem_last[i_cmd.rd_addr];
            r_rd_idx   <= i_cmd.rd_addr;
            r_rd_used  <= r_used[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.wr_en) begin
                r_used[i_cmd.wr_idx] <= 1'b1;
            end
            if (i_cmd.clr_en) begin
                r_used[i_cmd.clr_idx] <= 1'b0;
            end
        end
    end

    assign o_beat.vld     = r_rd_vld;
    assign o_beat.idx     = r_rd_idx;
    assign o_beat.used    = r_rd_used;
    assign o_beat.begin_a = r_rd_begin;
    assign o_beat.last_a  = r_rd_last;

    a_wr_sets_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en && !i_cmd.clr_en |=> r_used[$past(i_cmd.wr_idx)])
        else $error("written slot not marked used");

    a_clr_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_en && !i_cmd.wr_en |=> !r_used[$past(i_cmd.clr_idx)])
        else $error("taken slot still marked used");

endmodule

>>> rtl/ffea_scan.sv
module ffea_scan (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_clear,
    input  logic                             i_fit_mode,
    input  ffea_pkg::t_rd_beat               i_beat,
    input  logic [ffea_pkg::NEED_BITS-1:0]   i_need_m1,
    input  logic [ffea_pkg::ADDR_BITS-1:0]   i_key,
    output ffea_pkg::t_scan_res              o_res
);

    ffea_pkg::t_scan_res            r_res;
    logic [ffea_pkg::ADDR_BITS:0]   diff;
    logic                           fits;
    logic                           lower;

    // length >= need  <=>  last - begin >= need - 1 with last >= begin
    assign diff  = {1'b0, i_beat.last_a} - {1'b0, i_beat.begin_a};
    assign fits  = i_beat.used && !diff[ffea_pkg::ADDR_BITS]
                && (diff[ffea_pkg::ADDR_BITS-1:0] >= ffea_pkg::ADDR_BITS'(i_need_m1));
    assign lower = !r_res.fit_hit || (i_beat.begin_a < r_res.fit_begin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_res.fit_hit   <= 1'b0;
            r_res.match_hit <= 1'b0;
            r_res.free_hit  <= 1'b0;
        end else if (i_beat.vld) begin
            if (i_fit_mode) begin
                if (fits && lower) begin
                    r_res.fit_hit   <= 1'b1;
                    r_res.fit_idx   <= i_beat.idx;
                    r_res.fit_begin <= i_beat.begin_a;
                    r_res.fit_last  <= i_beat.last_a;
                end
            end else begin
                if (i_beat.used && !r_res.match_hit && i_beat.begin_a == i_key) begin
                    r_res.match_hit <= 1'b1;
                    r_res.match_idx <= i_beat.idx;
                end
                if (!i_beat.used && !r_res.free_hit) begin
                    r_res.free_hit <= 1'b1;
                    r_res.free_idx <= i_beat.idx;
                end
            end
        end
    end

    assign o_res = r_res;

    a_fit_well_formed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.fit_hit |-> r_res.fit_last >= r_res.fit_begin)
        else $error("chosen extent is malformed");

endmodule

>>> rtl/first_fit_extent_allocator.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  request beat, tuser = req_type
// m_axis    out  m_axis_tvalid / m_axis_tready  one result beat per request
// cfg       in   i_cfg_we                       i_cfg_idx, i_cfg_data
//
// insert: fit scan, one free slot per cycle through the table read port;
// growing update: fit scan, then free scan; remove and release: free scan;
// shrinking update or persist off: straight to the result state
// reset clears the slot used bits at once, end pointer 0, persist on
// s_axis_tready is high only in idle; a stalled result holds in the output
// register and the block waits before loading the next one
module first_fit_extent_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ffea_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ffea_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // key_length, value_length, old_value_length, old_start, old_end
    input  logic [ffea_pkg::S_DATA_W-1:0]     s_axis_tdata,
    // req_type
    input  logic [ffea_pkg::S_USER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // write_valid, write_start, write_end, tomb_valid, tomb_start, tomb_end, status
    output logic [ffea_pkg::M_DATA_W-1:0]     m_axis_tdata
);

    localparam int AW = ffea_pkg::ADDR_BITS;
    localparam int NW = ffea_pkg::NEED_BITS;
    localparam int FW = ffea_pkg::FIELD_W;

    ffea_pkg::t_state r_state, n_state;

    logic                          accept;
    ffea_pkg::t_req                in_req;
    logic [ffea_pkg::KLEN_W-1:0]   in_klen;
    logic [ffea_pkg::VLEN_W-1:0]   in_vlen;
    logic [ffea_pkg::VLEN_W-1:0]   in_ovlen;
    logic [FW-1:0]                 in_os;
    logic [FW-1:0]                 in_oe;
    logic                          in_grow;
    logic [NW-1:0]                 n_need_m1;

    logic                          r_persist;
    logic [AW-1:0]                 r_end;
    ffea_pkg::t_req                r_req;
    logic [AW-1:0]                 r_os;
    logic [AW-1:0]                 r_oe;
    logic [NW-1:0]                 r_need_m1;
    logic [NW-1:0]                 need;
    logic [AW-1:0]                 end_next;
    logic [ffea_pkg::CNT_W-1:0]    r_cnt;

    logic                          r_wv, r_tv, r_st;
    logic [AW-1:0]                 r_ws, r_we, r_ts, r_te;
    logic                          n_wv, n_tv;
    logic [AW-1:0]                 n_ws, n_we, n_ts, n_te;
    logic                          r_m_valid;
    logic [ffea_pkg::M_DATA_W-1:0] r_m_data;

    logic                          cnt_clr;
    logic                          scan_done;
    logic                          load_out;
    logic                          fit_miss;
    ffea_pkg::t_tbl_cmd            tbl_cmd;
    ffea_pkg::t_rd_beat            beat;
    ffea_pkg::t_scan_res           scan_res;

    assign in_req   = ffea_pkg::t_req'(s_axis_tuser);
    assign in_klen  = s_axis_tdata[15:0];
    assign in_vlen  = s_axis_tdata[35:16];
    assign in_ovlen = s_axis_tdata[55:36];
    assign in_os    = s_axis_tdata[86:56];
    assign in_oe    = s_axis_tdata[117:87];
    // same key on both sides, so growth is only in the value
    assign in_grow  = in_vlen > in_ovlen;
    assign n_need_m1 = NW'(ffea_pkg::HEADER_BYTES + ffea_pkg::TERM_BYTES - 1)
                     + NW'(in_klen) + NW'(in_vlen);

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign need      = r_need_m1 + NW'(1);
    assign end_next  = r_end + AW'(need);
    assign scan_done = (r_cnt == ffea_pkg::CNT_W'(ffea_pkg::FREE_SLOTS)) && !beat.vld;
    assign fit_miss  = (r_state == ffea_pkg::ST_FIT_COMMIT) && !scan_res.fit_hit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffea_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!r_persist) begin
                        n_state = ffea_pkg::ST_RESULT;
                    end else begin
                        unique case (in_req)
                            ffea_pkg::REQ_INSERT:  n_state = ffea_pkg::ST_FIT_SCAN;
                            ffea_pkg::REQ_UPDATE:  n_state = in_grow ? ffea_pkg::ST_FIT_SCAN
                                                                     : ffea_pkg::ST_RESULT;
                            ffea_pkg::REQ_REMOVE:  n_state = ffea_pkg::ST_FREE_SCAN;
                            ffea_pkg::REQ_RELEASE: n_state = ffea_pkg::ST_FREE_SCAN;
                            default:               n_state = ffea_pkg::ST_RESULT;
                        endcase
                    end
                end
            end
            ffea_pkg::ST_FIT_SCAN: begin
                if (scan_done) n_state = ffea_pkg::ST_FIT_COMMIT;
            end
            ffea_pkg::ST_FIT_COMMIT: begin
                n_state = (r_req == ffea_pkg::REQ_UPDATE) ? ffea_pkg::ST_FREE_SCAN
                                                          : ffea_pkg::ST_RESULT;
            end
            ffea_pkg::ST_FREE_SCAN: begin
                if (scan_done) n_state = ffea_pkg::ST_FREE_COMMIT;
            end
            ffea_pkg::ST_FREE_COMMIT: begin
                n_state = ffea_pkg::ST_RESULT;
            end
            ffea_pkg::ST_RESULT: begin
                if (!r_m_valid || m_axis_tready) n_state = ffea_pkg::ST_IDLE;
            end
            default: n_state = ffea_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready    = 1'b0;
        cnt_clr          = 1'b0;
        load_out         = 1'b0;
        tbl_cmd          = '0;
        tbl_cmd.rd_addr  = r_cnt[ffea_pkg::IDX_W-1:0];
        tbl_cmd.wr_begin = r_os;
        tbl_cmd.wr_last  = r_oe;
        unique case (r_state) inside
            ffea_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                cnt_clr       = 1'b1;
            end
            ffea_pkg::ST_FIT_SCAN, ffea_pkg::ST_FREE_SCAN: begin
                tbl_cmd.rd_en = r_cnt < ffea_pkg::CNT_W'(ffea_pkg::FREE_SLOTS);
            end
            ffea_pkg::ST_FIT_COMMIT: begin
                cnt_clr         = 1'b1;
                tbl_cmd.clr_en  = scan_res.fit_hit;
                tbl_cmd.clr_idx = scan_res.fit_idx;
            end
            ffea_pkg::ST_FREE_COMMIT: begin
                // one entry per start: an existing start only gets a new last
                if (scan_res.match_hit) begin
                    tbl_cmd.wr_en  = 1'b1;
                    tbl_cmd.wr_idx = scan_res.match_idx;
                end else if (scan_res.free_hit) begin
                    tbl_cmd.wr_en  = 1'b1;
                    tbl_cmd.wr_idx = scan_res.free_idx;
                end
            end
            ffea_pkg::ST_RESULT: begin
                load_out = !r_m_valid || m_axis_tready;
            end
            default: begin
                cnt_clr = 1'b1;
            end
        endcase
    end

    // result fields known at the request beat
    always_comb begin
        n_wv = 1'b0;
        n_ws = '0;
        n_we = '0;
        n_tv = 1'b0;
        n_ts = '0;
        n_te = '0;
        if (r_persist) begin
            case (in_req)
                ffea_pkg::REQ_INSERT: begin
                    n_wv = 1'b1;
                end
                ffea_pkg::REQ_UPDATE: begin
                    n_wv = 1'b1;
                    if (in_grow) begin
                        n_tv = 1'b1;
                        n_ts = AW'(in_os);
                        n_te = AW'(in_oe);
                    end else begin
                        n_ws = AW'(in_os);
                        n_we = AW'(in_oe);
                    end
                end
                ffea_pkg::REQ_REMOVE: begin
                    n_tv = 1'b1;
                    n_ts = AW'(in_os);
                    n_te = AW'(in_oe);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ffea_pkg::ST_IDLE;
            r_persist <= 1'b1;
            r_end     <= '0;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_idx == ffea_pkg::CFG_PERSIST) begin
                r_persist <= i_cfg_data[0];
            end
            if (i_cfg_we && i_cfg_idx == ffea_pkg::CFG_FILE_END) begin
                r_end <= AW'(i_cfg_data);
            end else if (fit_miss) begin
                r_end <= end_next;
            end
            if (cnt_clr) begin
                r_cnt <= '0;
            end else if (tbl_cmd.rd_en) begin
                r_cnt <= r_cnt + ffea_pkg::CNT_W'(1);
            end
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req     <= in_req;
            r_os      <= AW'(in_os);
            r_oe      <= AW'(in_oe);
            r_need_m1 <= n_need_m1;
            r_wv      <= n_wv;
            r_ws      <= n_ws;
            r_we      <= n_we;
            r_tv      <= n_tv;
            r_ts      <= n_ts;
            r_te      <= n_te;
            r_st      <= 1'b0;
        end
        if (r_state == ffea_pkg::ST_FIT_COMMIT) begin
            if (scan_res.fit_hit) begin
                r_ws <= scan_res.fit_begin;
                r_we <= scan_res.fit_last;
            end else begin
                r_ws <= r_end;
                r_we <= end_next - AW'(1);
            end
        end
        if (r_state == ffea_pkg::ST_FREE_COMMIT) begin
            r_st <= !scan_res.match_hit && !scan_res.free_hit;
        end
        if (load_out) begin
            r_m_data <= {1'b0, r_st, FW'(r_te), FW'(r_ts), r_tv,
                         FW'(r_we), FW'(r_ws), r_wv};
        end
    end

    ffea_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .o_beat  (beat)
    );

    ffea_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cnt_clr),
        .i_fit_mode (r_state == ffea_pkg::ST_FIT_SCAN),
        .i_beat     (beat),
        .i_need_m1  (r_need_m1),
        .i_key      (r_os),
        .o_res      (scan_res)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != ffea_pkg::ST_IDLE)
        else $error("request beat taken but sequencer stayed idle");

    a_append_moves_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fit_miss |=> r_end == $past(end_next))
        else $error("append did not advance the end pointer");

    a_result_from_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> r_state == ffea_pkg::ST_RESULT && !(r_m_valid && !m_axis_tready))
        else $error("result loaded over a pending beat");

endmodule
